@@ rtl/core/xmt_pkg.sv @@
// ----------------------------------------------------------------------------
// xmt_pkg
// Shared types and constants of the XML markup event tokenizer.
// ----------------------------------------------------------------------------
package xmt_pkg;

    // default width of the internal length counters
    localparam int LENGTH_BITS_DEFAULT = 16;

    // result queue geometry
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

    // byte codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_QUEST = 8'h3F;

    // reported event kinds
    typedef enum logic [3:0] {
        EV_DATA    = 4'd0,
        EV_WS      = 4'd1,
        EV_BEGIN   = 4'd2,
        EV_END     = 4'd3,
        EV_EMPTY   = 4'd4,
        EV_COMMENT = 4'd5,
        EV_PI      = 4'd6,
        EV_EOF     = 4'd7,
        EV_INVALID = 4'd8
    } event_kind_t;

    // one reported event
    typedef struct packed {
        event_kind_t event_kind;
        logic [15:0] content_length;
        logic [15:0] total_length;
        logic        length_saturated;
    } result_t;

    // results produced by one accepted byte, first one in r0
    typedef struct packed {
        logic    v0;
        logic    v1;
        result_t r0;
        result_t r1;
    } core_out_t;

endpackage

@@ rtl/core/xmt_core.sv @@
// ----------------------------------------------------------------------------
// xmt_core
// Lexer state and per-byte next-state logic; yields up to two events per byte.
// ----------------------------------------------------------------------------
module xmt_core #(
    parameter int LENGTH_BITS = xmt_pkg::LENGTH_BITS_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_fire,
    input  logic [7:0]         in_data,
    input  logic               in_last,
    output xmt_pkg::core_out_t res
);

    typedef enum logic [8:0] {
        PH_IDLE         = 9'b000000001,
        PH_TEXT         = 9'b000000010,
        PH_LT           = 9'b000000100,
        PH_LT_BANG      = 9'b000001000,
        PH_LT_BANG_DASH = 9'b000010000,
        PH_COMMENT      = 9'b000100000,
        PH_PI           = 9'b001000000,
        PH_END_TAG      = 9'b010000000,
        PH_BEGIN_TAG    = 9'b100000000
    } phase_t;

    typedef logic [LENGTH_BITS-1:0] cnt_t;

    phase_t     phase_reg, phase_next;
    logic [1:0] dm_reg, dm_next;
    cnt_t       cc_reg, cc_next;
    cnt_t       tc_reg, tc_next;
    logic       ws_reg, ws_next;
    logic       slash_reg, slash_next;
    logic       ovf_reg, ovf_next;

    // saturating add, carry out in the top bit
    function automatic logic [LENGTH_BITS:0] sat_add(input cnt_t a, input logic [1:0] b);
        logic [LENGTH_BITS:0] s;
        s = {1'b0, a} + {{(LENGTH_BITS-1){1'b0}}, b};
        if (s[LENGTH_BITS]) begin
            sat_add = {1'b1, {LENGTH_BITS{1'b1}}};
        end else begin
            sat_add = s;
        end
    endfunction

    // low 16 bits of a counter, zero extended when the counter is narrower
    function automatic logic [15:0] len16(input cnt_t x);
        logic [LENGTH_BITS+15:0] w;
        w = {16'b0, x};
        len16 = w[15:0];
    endfunction

    function automatic xmt_pkg::result_t mk(input xmt_pkg::event_kind_t k, input cnt_t c,
                                            input cnt_t t, input logic s);
        xmt_pkg::result_t r;
        r.event_kind       = k;
        r.content_length   = len16(c);
        r.total_length     = len16(t);
        r.length_saturated = s;
        mk = r;
    endfunction

    // next state and events for the byte at the input
    always_comb begin
        logic [LENGTH_BITS:0] sum;
        logic                 is_ws;
        logic                 do_tag;
        logic                 has_a, has_b, has_c;
        xmt_pkg::result_t     ev_a, ev_b, ev_c;

        phase_next = phase_reg;
        dm_next    = dm_reg;
        cc_next    = cc_reg;
        tc_next    = tc_reg;
        ws_next    = ws_reg;
        slash_next = slash_reg;
        ovf_next   = ovf_reg;
        has_a = 1'b0;
        has_b = 1'b0;
        has_c = 1'b0;
        ev_a  = '0;
        ev_b  = '0;
        ev_c  = '0;
        do_tag = 1'b0;
        sum    = '0;
        is_ws  = in_data inside {xmt_pkg::CH_CR, xmt_pkg::CH_LF, xmt_pkg::CH_TAB,
                                 xmt_pkg::CH_SPACE};

        case (phase_reg)
            PH_IDLE: begin
                dm_next = '0; cc_next = '0; tc_next = '0;
                ws_next = 1'b1; slash_next = 1'b0; ovf_next = 1'b0;
                if (in_data == xmt_pkg::CH_NUL) begin
                    has_a = 1'b1;
                    ev_a  = mk(xmt_pkg::EV_EOF, cnt_t'(1), cnt_t'(1), 1'b0);
                end else if (in_data == xmt_pkg::CH_LT) begin
                    tc_next    = cnt_t'(1);
                    phase_next = PH_LT;
                end else begin
                    tc_next    = cnt_t'(1);
                    cc_next    = cnt_t'(1);
                    ws_next    = is_ws;
                    phase_next = PH_TEXT;
                end
            end
            PH_TEXT: begin
                if (in_data == xmt_pkg::CH_LT || in_data == xmt_pkg::CH_NUL) begin
                    has_a = 1'b1;
                    ev_a  = mk(ws_reg ? xmt_pkg::EV_WS : xmt_pkg::EV_DATA,
                               cc_reg, tc_reg, ovf_reg);
                    dm_next = '0; cc_next = '0; tc_next = '0;
                    ws_next = 1'b1; slash_next = 1'b0; ovf_next = 1'b0;
                    if (in_data == xmt_pkg::CH_LT) begin
                        tc_next    = cnt_t'(1);
                        phase_next = PH_LT;
                    end else begin
                        has_b      = 1'b1;
                        ev_b       = mk(xmt_pkg::EV_EOF, cnt_t'(1), cnt_t'(1), 1'b0);
                        phase_next = PH_IDLE;
                    end
                end else begin
                    sum      = sat_add(tc_reg, 2'd1);
                    tc_next  = sum[LENGTH_BITS-1:0];
                    ovf_next = ovf_next | sum[LENGTH_BITS];
                    sum      = sat_add(cc_reg, 2'd1);
                    cc_next  = sum[LENGTH_BITS-1:0];
                    ovf_next = ovf_next | sum[LENGTH_BITS];
                    ws_next  = ws_reg & is_ws;
                end
            end
            default: begin
                if (in_data == xmt_pkg::CH_NUL) begin
                    // markup cut short by the end marker
                    sum   = sat_add(cc_reg, dm_reg);
                    has_a = 1'b1;
                    ev_a  = mk(xmt_pkg::EV_INVALID, sum[LENGTH_BITS-1:0], tc_reg,
                               ovf_reg | sum[LENGTH_BITS]);
                    has_b = 1'b1;
                    ev_b  = mk(xmt_pkg::EV_EOF, cnt_t'(1), cnt_t'(1), 1'b0);
                    dm_next = '0; cc_next = '0; tc_next = '0;
                    ws_next = 1'b1; slash_next = 1'b0; ovf_next = 1'b0;
                    phase_next = PH_IDLE;
                end else begin
                    sum      = sat_add(tc_reg, 2'd1);
                    tc_next  = sum[LENGTH_BITS-1:0];
                    ovf_next = ovf_reg | sum[LENGTH_BITS];
                    case (phase_reg)
                        PH_LT: begin
                            if (in_data == xmt_pkg::CH_QUEST) begin
                                phase_next = PH_PI;
                            end else if (in_data == xmt_pkg::CH_SLASH) begin
                                phase_next = PH_END_TAG;
                            end else if (in_data == xmt_pkg::CH_BANG) begin
                                cc_next    = cnt_t'(1);
                                phase_next = PH_LT_BANG;
                            end else begin
                                do_tag = 1'b1;
                            end
                        end
                        PH_LT_BANG: begin
                            if (in_data == xmt_pkg::CH_DASH) begin
                                cc_next    = cnt_t'(2);
                                phase_next = PH_LT_BANG_DASH;
                            end else begin
                                do_tag = 1'b1;
                            end
                        end
                        PH_LT_BANG_DASH: begin
                            if (in_data == xmt_pkg::CH_DASH) begin
                                cc_next    = '0;
                                dm_next    = '0;
                                phase_next = PH_COMMENT;
                            end else begin
                                do_tag = 1'b1;
                            end
                        end
                        PH_COMMENT: begin
                            if (in_data == xmt_pkg::CH_DASH) begin
                                if (dm_reg >= 2'd2) begin
                                    sum      = sat_add(cc_reg, 2'd1);
                                    cc_next  = sum[LENGTH_BITS-1:0];
                                    ovf_next = ovf_next | sum[LENGTH_BITS];
                                end else begin
                                    dm_next = dm_reg + 2'd1;
                                end
                            end else if (in_data == xmt_pkg::CH_GT && dm_reg >= 2'd2) begin
                                has_a = 1'b1;
                                ev_a  = mk(xmt_pkg::EV_COMMENT, cc_reg, tc_next, ovf_next);
                                dm_next = '0; cc_next = '0; tc_next = '0;
                                ws_next = 1'b1; slash_next = 1'b0; ovf_next = 1'b0;
                                phase_next = PH_IDLE;
                            end else begin
                                // pending dashes fold back into the content
                                sum      = sat_add(cc_reg, dm_reg + 2'd1);
                                cc_next  = sum[LENGTH_BITS-1:0];
                                ovf_next = ovf_next | sum[LENGTH_BITS];
                                dm_next  = '0;
                            end
                        end
                        PH_PI: begin
                            if (in_data == xmt_pkg::CH_QUEST) begin
                                if (dm_reg >= 2'd1) begin
                                    sum      = sat_add(cc_reg, 2'd1);
                                    cc_next  = sum[LENGTH_BITS-1:0];
                                    ovf_next = ovf_next | sum[LENGTH_BITS];
                                end else begin
                                    dm_next = 2'd1;
                                end
                            end else if (in_data == xmt_pkg::CH_GT && dm_reg >= 2'd1) begin
                                has_a = 1'b1;
                                ev_a  = mk(xmt_pkg::EV_PI, cc_reg, tc_next, ovf_next);
                                dm_next = '0; cc_next = '0; tc_next = '0;
                                ws_next = 1'b1; slash_next = 1'b0; ovf_next = 1'b0;
                                phase_next = PH_IDLE;
                            end else begin
                                sum      = sat_add(cc_reg, dm_reg + 2'd1);
                                cc_next  = sum[LENGTH_BITS-1:0];
                                ovf_next = ovf_next | sum[LENGTH_BITS];
                                dm_next  = '0;
                            end
                        end
                        PH_END_TAG: begin
                            if (in_data == xmt_pkg::CH_GT) begin
                                has_a = 1'b1;
                                ev_a  = mk(xmt_pkg::EV_END, cc_reg, tc_next, ovf_next);
                                dm_next = '0; cc_next = '0; tc_next = '0;
                                ws_next = 1'b1; slash_next = 1'b0; ovf_next = 1'b0;
                                phase_next = PH_IDLE;
                            end else begin
                                sum      = sat_add(cc_reg, 2'd1);
                                cc_next  = sum[LENGTH_BITS-1:0];
                                ovf_next = ovf_next | sum[LENGTH_BITS];
                            end
                        end
                        PH_BEGIN_TAG: begin
                            do_tag = 1'b1;
                        end
                        default: begin
                            dm_next = '0; cc_next = '0; tc_next = '0;
                            ws_next = 1'b1; slash_next = 1'b0; ovf_next = 1'b0;
                            phase_next = PH_IDLE;
                        end
                    endcase

                    // byte of a begin tag, also taken by prefixes that did not match
                    if (do_tag) begin
                        phase_next = PH_BEGIN_TAG;
                        if (in_data == xmt_pkg::CH_GT) begin
                            has_a = 1'b1;
                            if (slash_reg) begin
                                ev_a = mk(xmt_pkg::EV_EMPTY,
                                          (cc_next != '0) ? cc_next - cnt_t'(1) : '0,
                                          tc_next, ovf_next);
                            end else begin
                                ev_a = mk(xmt_pkg::EV_BEGIN, cc_next, tc_next, ovf_next);
                            end
                            dm_next = '0; cc_next = '0; tc_next = '0;
                            ws_next = 1'b1; slash_next = 1'b0; ovf_next = 1'b0;
                            phase_next = PH_IDLE;
                        end else begin
                            sum        = sat_add(cc_next, 2'd1);
                            cc_next    = sum[LENGTH_BITS-1:0];
                            ovf_next   = ovf_next | sum[LENGTH_BITS];
                            slash_next = (in_data == xmt_pkg::CH_SLASH);
                        end
                    end
                end
            end
        endcase

        // stream ends with an event still open
        if (in_last && phase_next != PH_IDLE) begin
            has_c = 1'b1;
            if (phase_next == PH_TEXT) begin
                ev_c = mk(ws_next ? xmt_pkg::EV_WS : xmt_pkg::EV_DATA,
                          cc_next, tc_next, ovf_next);
            end else begin
                sum  = sat_add(cc_next, dm_next);
                ev_c = mk(xmt_pkg::EV_INVALID, sum[LENGTH_BITS-1:0], tc_next,
                          ovf_next | sum[LENGTH_BITS]);
            end
            dm_next = '0; cc_next = '0; tc_next = '0;
            ws_next = 1'b1; slash_next = 1'b0; ovf_next = 1'b0;
            phase_next = PH_IDLE;
        end

        // pack events into result slots, first one in slot zero
        res.v0 = in_fire & (has_a | has_c);
        res.r0 = has_a ? ev_a : ev_c;
        res.v1 = in_fire & (has_b | (has_a & has_c));
        res.r1 = has_b ? ev_b : ev_c;
    end

    // lexer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            dm_reg    <= '0;
            cc_reg    <= '0;
            tc_reg    <= '0;
            ws_reg    <= 1'b1;
            slash_reg <= 1'b0;
            ovf_reg   <= 1'b0;
        end else if (in_fire) begin
            phase_reg <= phase_next;
            dm_reg    <= dm_next;
            cc_reg    <= cc_next;
            tc_reg    <= tc_next;
            ws_reg    <= ws_next;
            slash_reg <= slash_next;
            ovf_reg   <= ovf_next;
        end
    end

    // a byte flagged last leaves the lexer between events
    a_last_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && in_last |=> phase_reg == PH_IDLE)
        else $error("open event after last byte");

    // two events only from an end marker or the last byte
    a_two_events: assert property (@(posedge aclk) disable iff (!aresetn)
        res.v1 |-> (res.v0 && (in_data == xmt_pkg::CH_NUL || in_last)))
        else $error("unexpected second event");

endmodule

@@ rtl/core/xmt_out_fifo.sv @@
// ----------------------------------------------------------------------------
// xmt_out_fifo
// Result queue taking up to two events per cycle, one out per ready cycle.
// ----------------------------------------------------------------------------
module xmt_out_fifo (
    input  logic               aclk,
    input  logic               aresetn,
    input  xmt_pkg::core_out_t push,
    output logic               room,
    output logic               out_valid,
    input  logic               out_ready,
    output xmt_pkg::result_t   out_data
);

    localparam int PW = xmt_pkg::FIFO_PTR_W;
    localparam logic [PW:0] CNT_ROOM = (PW+1)'(xmt_pkg::FIFO_DEPTH - 2);
    localparam logic [PW:0] CNT_FULL = (PW+1)'(xmt_pkg::FIFO_DEPTH);
    localparam logic [PW-1:0] PTR_ONE = PW'(1);

    xmt_pkg::result_t mem [xmt_pkg::FIFO_DEPTH];

    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PW:0]   count_reg, count_next;
    logic [PW-1:0] wr_ptr_plus1;
    logic          pop;

    assign wr_ptr_plus1 = wr_ptr_reg + PTR_ONE;
    assign pop          = out_valid & out_ready;
    assign room         = (count_reg <= CNT_ROOM);
    assign out_valid    = (count_reg != '0);
    assign out_data     = mem[rd_ptr_reg];

    // pointer and occupancy update
    always_comb begin
        wr_ptr_next = wr_ptr_reg + {{(PW-1){1'b0}}, push.v0} + {{(PW-1){1'b0}}, push.v1};
        rd_ptr_next = rd_ptr_reg + {{(PW-1){1'b0}}, pop};
        count_next  = count_reg + {{PW{1'b0}}, push.v0} + {{PW{1'b0}}, push.v1}
                      - {{PW{1'b0}}, pop};
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push.v0) begin
            mem[wr_ptr_reg] <= push.r0;
        end
        if (push.v1) begin
            mem[wr_ptr_plus1] <= push.r1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_slot_order: assert property (@(posedge aclk) disable iff (!aresetn)
        push.v1 |-> push.v0)
        else $error("second slot written without first");

    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.v0 || push.v1) |-> count_reg <= CNT_ROOM)
        else $error("result queue overrun");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_FULL)
        else $error("result queue count out of range");

endmodule

@@ rtl/core/xml_markup_event_tokenizer.sv @@
// ----------------------------------------------------------------------------
// xml_markup_event_tokenizer
// Streaming XML lexer reporting text, tag, comment, PI, EOF and invalid events.
// ----------------------------------------------------------------------------
// One byte is accepted per clock while s_tready is high. Each byte updates the
// registered lexer state, and its events are written into a four-entry result
// queue that drives the master side from registers. A byte that closes two
// events at once (a NUL ending a text run or open markup, or a last byte
// ending an open event after another one closed) writes two entries, so
// s_tready drops whenever fewer than two entries are free. With a sink that
// takes one transaction per cycle the block sustains one byte per cycle; the
// queue absorbs the extra entry of an occasional two-event byte.
module xml_markup_event_tokenizer #(
    parameter int LENGTH_BITS = xmt_pkg::LENGTH_BITS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [15:0] content_length, [31:16] total_length
    output logic [4:0]  m_tuser    // [3:0] event_kind, [4] length_saturated
);

    xmt_pkg::core_out_t core_res;
    xmt_pkg::result_t   head;
    logic               in_fire;

    assign in_fire = s_tvalid & s_tready;

    // lexer
    xmt_core #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_fire (in_fire),
        .in_data (s_tdata),
        .in_last (s_tlast),
        .res     (core_res)
    );

    // result queue
    xmt_out_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (core_res),
        .room      (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (head)
    );

    // output packing
    assign m_tdata = {head.total_length, head.content_length};
    assign m_tuser = {head.length_saturated, head.event_kind};

endmodule
